// ----- rtl/psv_pkg.sv -----
// Shared types, constants and helper functions of the soft shadow visibility block.
// No dependencies; imported by the top, divider, datapath and controller files.
`timescale 1ns / 1ps
package psv_pkg;

    localparam int MAP_SIDE     = 256;
    localparam int MAP_LOG      = $clog2(MAP_SIDE);
    localparam int ADDR_W       = 2 * MAP_LOG;
    localparam int STORE_SIZE   = MAP_SIDE * MAP_SIDE;
    localparam int MAX_TAPS     = 64;
    localparam int TAP_W        = $clog2(MAX_TAPS + 1);
    localparam int DEPTH_BITS   = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
    localparam int TRIG_W       = CORDIC_W - 14;
    localparam int DIV_W        = ((TAP_W + 32 + 3) / 4) * 4;
    localparam int DIV_CYC      = DIV_W / 4;
    localparam int DIV_CNT_W    = $clog2(DIV_CYC + 1);
    localparam int SUM_W        = DEPTH_BITS + TAP_W;
    localparam int POS_W        = 56;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    localparam logic [2:0] REG_PENUMBRA = 3'd0;
    localparam logic [2:0] REG_MIN_RAD  = 3'd1;
    localparam logic [2:0] REG_MAX_RAD  = 3'd2;
    localparam logic [2:0] REG_BLK_TAPS = 3'd3;
    localparam logic [2:0] REG_FLT_TAPS = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] texel_address;
        logic [23:0] texel_depth;
        logic [15:0] u_coord;
        logic [15:0] v_coord;
        logic [23:0] receiver_depth;
        logic [15:0] rotation_angle;
    } request_t;

    typedef struct packed {
        logic [16:0] visibility;
        logic [6:0]  blocker_count;
    } result_t;

    typedef struct packed {
        logic write;
        logic load;
        logic filter;
        logic rad_mul;
        logic rad_clamp;
        logic tap_start;
        logic sqrt_start;
        logic mul1;
        logic mul2;
        logic addr;
        logic read;
        logic acc;
        logic tap_next;
        logic mean_start;
        logic vis_start;
        logic emit_full;
        logic emit_vis;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic cordic_busy;
        logic last_tap;
        logic no_blockers;
    } status_t;

    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [CORDIC_CNT_W-1:0] k);
        logic signed [CORDIC_W-1:0] a;
        case (k)
            4'd0:    a = CORDIC_W'(536870912);
            4'd1:    a = CORDIC_W'(316933406);
            4'd2:    a = CORDIC_W'(167458907);
            4'd3:    a = CORDIC_W'(85004756);
            4'd4:    a = CORDIC_W'(42667329);
            4'd5:    a = CORDIC_W'(21354465);
            4'd6:    a = CORDIC_W'(10679838);
            4'd7:    a = CORDIC_W'(5340245);
            4'd8:    a = CORDIC_W'(2670163);
            4'd9:    a = CORDIC_W'(1335087);
            4'd10:   a = CORDIC_W'(667544);
            4'd11:   a = CORDIC_W'(333772);
            4'd12:   a = CORDIC_W'(166886);
            4'd13:   a = CORDIC_W'(83443);
            4'd14:   a = CORDIC_W'(41722);
            default: a = CORDIC_W'(20861);
        endcase
        return a;
    endfunction

    function automatic logic [TAP_W-1:0] tap_limit(input logic [6:0] n);
        logic [TAP_W-1:0] r;
        if (n == 7'd0)
            r = TAP_W'(1);
        else if (32'(n) > MAX_TAPS)
            r = TAP_W'(MAX_TAPS);
        else
            r = TAP_W'(n);
        return r;
    endfunction

endpackage

// ----- rtl/pcss_shadow_visibility_top.sv -----
// Top level of the soft shadow visibility block: controller plus datapath.
// Depends on psv_pkg, psv_ctrl and psv_datapath.
`timescale 1ns / 1ps
// A transfer is taken when start is high and busy is low. A depth write leaves
// busy low. A query runs a blocker pass and, only if blockers are found, a
// filter pass. Each tap starts, waits on the shared divider (four quotient
// bits at a time), then on the square root unit (two bits at a time, the
// 16-step CORDIC runs alongside), then does two offset multiplies, the
// address, one depth map read and the accumulate. With blockers the result
// follows the mean divide, the filter pass and the visibility divide;
// without, it follows the blocker pass. busy is high from the cycle after a
// query transfer until the result cycle. The result appears on result with
// result_valid high for exactly one cycle and cannot be held off.
module pcss_shadow_visibility_top
    import psv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output result_t     result,
    output logic        result_valid
);

    cmd_t    cmd;
    status_t status;

    psv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    psv_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ----- rtl/psv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module psv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/psv_div.sv -----
// Restoring divider, four quotient bits per cycle, small divisor.
// Depends on psv_pkg.
`timescale 1ns / 1ps
module psv_div
    import psv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [TAP_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     q_reg, q_next;
    logic [TAP_W-1:0]     rem_reg, rem_next;
    logic [TAP_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [TAP_W:0]       trial;

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < 4; k++)
        begin
            trial  = {rem_next, q_next[DIV_W-1]};
            q_next = {q_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial     = trial - {1'b0, dsr_reg};
                q_next[0] = 1'b1;
            end
            rem_next = trial[TAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYC - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/psv_datapath.sv -----
// Datapath: registers, depth map, divider, square root, CORDIC and tap arithmetic.
// Depends on psv_pkg, psv_ram and psv_div.
`timescale 1ns / 1ps
module psv_datapath
    import psv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  request_t    request,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  cmd_t        cmd,
    output status_t     status,
    output result_t     result,
    output logic        result_valid
);

    logic [23:0] ppd_reg;
    logic [15:0] min_reg, max_reg;
    logic [6:0]  nb_reg, nf_reg;

    logic [15:0]             u_reg, v_reg, rot_reg;
    logic [DEPTH_BITS-1:0]   recv_reg;
    logic [48:0]             rprod_reg;
    logic [15:0]             radius_reg;
    logic [TAP_W-1:0]        tap_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [TAP_W-1:0]        cnt_reg, lit_reg;
    logic signed [36:0]      cr_reg, sr_reg;
    logic signed [53:0]      ox_reg, oy_reg;
    logic [ADDR_W-1:0]       addr_reg;
    result_t                 result_reg;
    logic                    result_valid_reg;

    logic [TAP_W-1:0] n_cur;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [TAP_W-1:0] div_divisor;
    logic             div_start, div_busy;
    logic [DEPTH_BITS-1:0] rdata;
    logic [24:0]      rad_a;
    logic [24:0]      rad_val;
    logic [15:0]      rad_hi, rad_clamped;
    logic [15:0]      ang_base, ang;

    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg, cxs, cys;
    logic [CORDIC_CNT_W-1:0]    ck_reg;
    logic                       cbusy_reg;
    logic [1:0]                 quad_reg;
    logic signed [TRIG_W-1:0]   xq, yq, cosv, sinv;

    logic [31:0] sq_v_reg, sq_v_next;
    logic [15:0] sq_root_reg, sq_root_next;
    logic [19:0] sq_rem_reg, sq_rem_next;
    logic [2:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [19:0] sq_trial;

    logic [MAP_LOG-1:0] tx, ty;

    function automatic logic [MAP_LOG-1:0] texel_coord(input logic [15:0] base,
                                                      input logic signed [53:0] off);
        logic signed [POS_W-1:0] pos, t;
        logic [MAP_LOG-1:0] c;
        pos = $signed({8'd0, base, 32'd0}) + POS_W'(off);
        t   = pos >>> (48 - MAP_LOG);
        if (t < 0)
            c = '0;
        else if (t > POS_W'(MAP_SIDE - 1))
            c = MAP_LOG'(MAP_SIDE - 1);
        else
            c = t[MAP_LOG-1:0];
        return c;
    endfunction

    assign n_cur = cmd.filter ? tap_limit(nf_reg) : tap_limit(nb_reg);

    // divider operand select
    always_comb
    begin
        div_start    = cmd.tap_start | cmd.mean_start | cmd.vis_start;
        div_dividend = DIV_W'({tap_reg, 32'd0});
        div_divisor  = n_cur;
        if (cmd.mean_start)
        begin
            div_dividend = DIV_W'(sum_reg);
            div_divisor  = cnt_reg;
        end
        else if (cmd.vis_start)
        begin
            div_dividend = DIV_W'({lit_reg, 16'd0});
            div_divisor  = tap_limit(nf_reg);
        end
    end

    psv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    psv_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write && (32'(request.texel_address) < STORE_SIZE)),
        .waddr (ADDR_W'(request.texel_address)),
        .wdata (DEPTH_BITS'(request.texel_depth)),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // radius operand and clamp
    always_comb
    begin
        if (cmd.filter)
            rad_a = {1'b0, div_q[DEPTH_BITS-1:0] - recv_reg};
        else
            rad_a = 25'h1000000 - {1'b0, recv_reg};
        rad_val = rprod_reg[48:24];
        rad_hi  = (max_reg < min_reg) ? min_reg : max_reg;
        if (rad_val < {9'd0, min_reg})
            rad_clamped = min_reg;
        else if (rad_val > {9'd0, rad_hi})
            rad_clamped = rad_hi;
        else
            rad_clamped = rad_val[15:0];
    end

    // tap angle: bit-reversed index plus rotation
    always_comb
    begin
        ang_base = '0;
        for (int j = 0; j < TAP_W; j++)
        begin
            ang_base[15-j] = tap_reg[j];
        end
        ang = ang_base + rot_reg;
    end

    // CORDIC step and quadrant fold
    always_comb
    begin
        cxs = cx_reg >>> ck_reg;
        cys = cy_reg >>> ck_reg;
        xq  = cx_reg[CORDIC_W-1:14];
        yq  = cy_reg[CORDIC_W-1:14];
        case (quad_reg)
            2'd0:    begin cosv = xq;  sinv = yq;  end
            2'd1:    begin cosv = -yq; sinv = xq;  end
            2'd2:    begin cosv = -xq; sinv = -yq; end
            default: begin cosv = yq;  sinv = -xq; end
        endcase
    end

    // square root, two result bits per cycle
    always_comb
    begin
        sq_v_next    = sq_v_reg;
        sq_root_next = sq_root_reg;
        sq_rem_next  = sq_rem_reg;
        sq_trial     = '0;
        for (int k = 0; k < 2; k++)
        begin
            sq_rem_next = {sq_rem_next[17:0], sq_v_next[31:30]};
            sq_v_next   = {sq_v_next[29:0], 2'b00};
            sq_trial    = {2'b00, sq_root_next, 2'b01};
            if (sq_rem_next >= sq_trial)
            begin
                sq_rem_next  = sq_rem_next - sq_trial;
                sq_root_next = {sq_root_next[14:0], 1'b1};
            end
            else
            begin
                sq_root_next = {sq_root_next[14:0], 1'b0};
            end
        end
    end

    assign tx = texel_coord(u_reg, ox_reg);
    assign ty = texel_coord(v_reg, oy_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppd_reg          <= 24'd65536;
            min_reg          <= 16'd64;
            max_reg          <= 16'd4096;
            nb_reg           <= 7'd16;
            nf_reg           <= 7'd16;
            cbusy_reg        <= 1'b0;
            ck_reg           <= '0;
            sq_busy_reg      <= 1'b0;
            sq_cnt_reg       <= '0;
            result_valid_reg <= 1'b0;
            tap_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PENUMBRA: ppd_reg <= cfg_data;
                    REG_MIN_RAD:  min_reg <= cfg_data[15:0];
                    REG_MAX_RAD:  max_reg <= cfg_data[15:0];
                    REG_BLK_TAPS: nb_reg  <= cfg_data[6:0];
                    REG_FLT_TAPS: nf_reg  <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd.tap_start)
            begin
                cbusy_reg <= 1'b1;
                ck_reg    <= '0;
            end
            else if (cbusy_reg)
            begin
                ck_reg <= ck_reg + 1'b1;
                if (ck_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1))
                begin
                    cbusy_reg <= 1'b0;
                end
            end
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 3'd7)
                begin
                    sq_busy_reg <= 1'b0;
                end
            end
            if (cmd.rad_clamp)
                tap_reg <= '0;
            else if (cmd.tap_next)
                tap_reg <= tap_reg + 1'b1;
            result_valid_reg <= cmd.emit_full | cmd.emit_vis;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_reg    <= request.u_coord;
            v_reg    <= request.v_coord;
            recv_reg <= DEPTH_BITS'(request.receiver_depth);
            rot_reg  <= request.rotation_angle;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            lit_reg  <= '0;
        end
        if (cmd.rad_mul)
            rprod_reg <= 49'(rad_a) * 49'(ppd_reg);
        if (cmd.rad_clamp)
            radius_reg <= rad_clamped;
        if (cmd.tap_start)
        begin
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= CORDIC_W'({ang[13:0], 16'd0});
            quad_reg <= ang[15:14];
        end
        else if (cbusy_reg)
        begin
            if (!cz_reg[CORDIC_W-1])
            begin
                cx_reg <= cx_reg - cys;
                cy_reg <= cy_reg + cxs;
                cz_reg <= cz_reg - atan_turn(ck_reg);
            end
            else
            begin
                cx_reg <= cx_reg + cys;
                cy_reg <= cy_reg - cxs;
                cz_reg <= cz_reg + atan_turn(ck_reg);
            end
        end
        if (cmd.sqrt_start)
        begin
            sq_v_reg    <= div_q[31:0];
            sq_root_reg <= '0;
            sq_rem_reg  <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_v_reg    <= sq_v_next;
            sq_root_reg <= sq_root_next;
            sq_rem_reg  <= sq_rem_next;
        end
        if (cmd.mul1)
        begin
            cr_reg <= 37'(cosv) * $signed({1'b0, sq_root_reg});
            sr_reg <= 37'(sinv) * $signed({1'b0, sq_root_reg});
        end
        if (cmd.mul2)
        begin
            ox_reg <= 54'(cr_reg) * $signed({1'b0, radius_reg});
            oy_reg <= 54'(sr_reg) * $signed({1'b0, radius_reg});
        end
        if (cmd.addr)
            addr_reg <= {ty, tx};
        if (cmd.acc)
        begin
            if (cmd.filter)
            begin
                if (recv_reg >= rdata)
                    lit_reg <= lit_reg + 1'b1;
            end
            else if (rdata > recv_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rdata);
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.emit_full)
        begin
            result_reg.visibility    <= 17'd65536;
            result_reg.blocker_count <= '0;
        end
        else if (cmd.emit_vis)
        begin
            result_reg.visibility    <= div_q[16:0];
            result_reg.blocker_count <= 7'(cnt_reg);
        end
    end

    assign status.div_busy    = div_busy;
    assign status.sqrt_busy   = sq_busy_reg;
    assign status.cordic_busy = cbusy_reg;
    assign status.last_tap    = ((tap_reg + 1'b1) == n_cur);
    assign status.no_blockers = (cnt_reg == '0);
    assign result             = result_reg;
    assign result_valid       = result_valid_reg;

endmodule

// ----- rtl/psv_ctrl.sv -----
// Controller: sequences writes, radius setup, both tap passes and the result.
// Depends on psv_pkg.
`timescale 1ns / 1ps
module psv_ctrl
    import psv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    action,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_RMUL, S_RCLAMP, S_TGO, S_TDIV, S_TSQRT, S_TMUL1, S_TMUL2,
        S_TADDR, S_TREAD, S_TACC, S_MEAN, S_MWAIT, S_VIS, S_VWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   filter_reg, filter_next;
    logic   busy_reg;

    always_comb
    begin
        state_next  = state_reg;
        filter_next = filter_reg;
        cmd         = '0;
        cmd.filter  = filter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action)
                    begin
                        cmd.load    = 1'b1;
                        cmd.filter  = 1'b0;
                        filter_next = 1'b0;
                        state_next  = S_RMUL;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            S_RMUL:
            begin
                cmd.rad_mul = 1'b1;
                state_next  = S_RCLAMP;
            end
            S_RCLAMP:
            begin
                cmd.rad_clamp = 1'b1;
                state_next    = S_TGO;
            end
            S_TGO:
            begin
                cmd.tap_start = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_TSQRT;
                end
            end
            S_TSQRT:
            begin
                if (!status.sqrt_busy && !status.cordic_busy)
                    state_next = S_TMUL1;
            end
            S_TMUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_TMUL2;
            end
            S_TMUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_TADDR;
            end
            S_TADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_TREAD;
            end
            S_TREAD:
            begin
                cmd.read   = 1'b1;
                state_next = S_TACC;
            end
            S_TACC:
            begin
                cmd.acc = 1'b1;
                if (status.last_tap)
                    state_next = filter_reg ? S_VIS : S_MEAN;
                else
                begin
                    cmd.tap_next = 1'b1;
                    state_next   = S_TGO;
                end
            end
            S_MEAN:
            begin
                if (status.no_blockers)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.mean_start = 1'b1;
                    state_next     = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (!status.div_busy)
                begin
                    filter_next = 1'b1;
                    state_next  = S_RMUL;
                end
            end
            S_VIS:
            begin
                cmd.vis_start = 1'b1;
                state_next    = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.emit_vis = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            filter_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filter_reg <= filter_next;
            busy_reg   <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule
